// ----- rtl/lpmr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared types and constants of the length-prefixed message ring.
// ----------------------------------------------------------------------------
package lpmr_pkg;

	localparam int HEADER_BYTES = 4;
	localparam int LEN_W = 10;
	localparam int USED_W = 11;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_READ = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_TOO_LONG = 2'd1,
		STAT_NO_ROOM = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR_HDR,
		ST_HDR_RD,
		ST_DATA_RD,
		ST_DATA_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		req_kind_t req_type;
		logic [7:0] data_byte;
		logic end_of_message;
		logic empty_message;
	} req_t;

	typedef struct packed {
		status_t status;
		logic [7:0] data_out;
		logic data_valid;
		logic last_of_message;
		logic [LEN_W-1:0] message_length;
		logic [USED_W-1:0] used_bytes;
	} rsp_t;

endpackage

// ----- rtl/lpmr_ram.sv -----
// ----------------------------------------------------------------------------
// lpmr_ram
// Single-port byte memory with a registered read.
// ----------------------------------------------------------------------------
module lpmr_ram #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input logic clk,
	input logic en,
	input logic we,
	input logic [AW-1:0] addr,
	input logic [7:0] wdata,
	output logic [7:0] rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ----- rtl/lpmr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpmr_ctrl
// Sequencer of the message ring: pointers, write staging, header write and
// fetch, byte reads, and the finished result for one transaction.
// ----------------------------------------------------------------------------
module lpmr_ctrl import lpmr_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_t req,
	output logic done_valid,
	input logic done_ready,
	output rsp_t done_rsp,
	output logic mem_en,
	output logic mem_we,
	output logic [$clog2(CAPACITY)-1:0] mem_addr,
	output logic [7:0] mem_wdata,
	input logic [7:0] mem_rdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int PW = AW + 1;
	localparam int MAX_PAYLOAD = CAPACITY - HEADER_BYTES;

	state_t state_q, state_d;
	logic [PW-1:0] head_q, head_d;
	logic [PW-1:0] tail_q, tail_d;
	logic [AW-1:0] staged_q, staged_d;
	status_t fail_q, fail_d;
	logic [AW-1:0] roff_q, roff_d;
	logic [AW-1:0] rlen_q, rlen_d;
	logic ractive_q, ractive_d;
	logic [1:0] cnt_q, cnt_d;
	logic [23:0] hdr_q, hdr_d;
	rsp_t res_q, res_d;

	logic [PW-1:0] used_w;
	logic [PW-1:0] room_w;
	logic [PW-1:0] nl_w;
	logic [PW-1:0] off_next;
	logic wr_skip;
	logic wr_take;
	logic wr_commit;
	status_t wfail_n;
	logic [31:0] hdr_full;
	logic [AW-1:0] hdr_len;
	logic [31:0] hdr_word;
	logic [AW-1:0] rd_addr;

	// Admission checks and header decode.
	always_comb begin
		used_w = head_q - tail_q;
		room_w = (used_w >= PW'(CAPACITY)) ? '0 : PW'(CAPACITY) - used_w;
		nl_w = PW'(staged_q) + PW'(1);
		off_next = PW'(roff_q) + PW'(1);
		wr_skip = req.end_of_message & req.empty_message;
		wfail_n = fail_q;
		wr_take = 1'b0;
		if (fail_q == STAT_OK) begin
			if (!wr_skip) begin
				if (nl_w > PW'(MAX_PAYLOAD)) begin
					wfail_n = STAT_TOO_LONG;
				end else if (PW'(HEADER_BYTES) + nl_w > room_w) begin
					wfail_n = STAT_NO_ROOM;
				end else begin
					wr_take = 1'b1;
				end
			end else if (PW'(HEADER_BYTES) + PW'(staged_q) > room_w) begin
				wfail_n = STAT_NO_ROOM;
			end
		end
		wr_commit = req.end_of_message && (wfail_n == STAT_OK);
		hdr_full = {mem_rdata, hdr_q};
		hdr_len = (hdr_full > 32'(MAX_PAYLOAD)) ? AW'(MAX_PAYLOAD) : hdr_full[AW-1:0];
		hdr_word = 32'(staged_q);
		rd_addr = tail_q[AW-1:0] + AW'(HEADER_BYTES) + roff_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req.req_type == REQ_WRITE) begin
						state_d = wr_commit ? ST_WR_HDR : ST_DONE;
					end else if (ractive_q) begin
						state_d = ST_DATA_WAIT;
					end else if (used_w == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_HDR_RD;
					end
				end
			end
			ST_WR_HDR: begin
				if (cnt_q == 2'd3) begin
					state_d = ST_DONE;
				end
			end
			ST_HDR_RD: begin
				if (cnt_q == 2'd3) begin
					state_d = (hdr_len == '0) ? ST_DONE : ST_DATA_RD;
				end
			end
			ST_DATA_RD: state_d = ST_DATA_WAIT;
			ST_DATA_WAIT: state_d = ST_DONE;
			ST_DONE: begin
				if (done_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		staged_d = staged_q;
		fail_d = fail_q;
		roff_d = roff_q;
		rlen_d = rlen_q;
		ractive_d = ractive_q;
		cnt_d = cnt_q;
		hdr_d = hdr_q;
		res_d = res_q;
		mem_en = 1'b0;
		mem_we = 1'b0;
		mem_addr = '0;
		mem_wdata = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					res_d = '0;
					cnt_d = '0;
					if (req.req_type == REQ_WRITE) begin
						fail_d = wfail_n;
						res_d.status = wfail_n;
						if (wr_take) begin
							mem_en = 1'b1;
							mem_we = 1'b1;
							mem_addr = head_q[AW-1:0] + AW'(HEADER_BYTES) + staged_q;
							mem_wdata = req.data_byte;
							staged_d = nl_w[AW-1:0];
						end
						if (req.end_of_message) begin
							if (wfail_n != STAT_OK) begin
								// drop the whole message and clear the failure
								fail_d = STAT_OK;
								staged_d = '0;
							end else begin
								res_d.last_of_message = 1'b1;
								res_d.message_length = LEN_W'(staged_d);
							end
						end
					end else if (ractive_q) begin
						mem_en = 1'b1;
						mem_addr = rd_addr;
					end else if (used_w == '0) begin
						res_d.status = STAT_EMPTY;
					end else begin
						mem_en = 1'b1;
						mem_addr = tail_q[AW-1:0];
					end
				end
			end
			ST_WR_HDR: begin
				mem_en = 1'b1;
				mem_we = 1'b1;
				mem_addr = head_q[AW-1:0] + AW'(cnt_q);
				mem_wdata = hdr_word[cnt_q*8 +: 8];
				cnt_d = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					head_d = head_q + PW'(HEADER_BYTES) + PW'(staged_q);
					staged_d = '0;
				end
			end
			ST_HDR_RD: begin
				if (cnt_q != 2'd3) begin
					hdr_d[cnt_q*8 +: 8] = mem_rdata;
					mem_en = 1'b1;
					mem_addr = tail_q[AW-1:0] + AW'(cnt_q) + AW'(1);
					cnt_d = cnt_q + 2'd1;
				end else begin
					rlen_d = hdr_len;
					roff_d = '0;
					if (hdr_len == '0) begin
						// empty message: free its header right away
						tail_d = tail_q + PW'(HEADER_BYTES);
						res_d.last_of_message = 1'b1;
					end else begin
						ractive_d = 1'b1;
					end
				end
			end
			ST_DATA_RD: begin
				mem_en = 1'b1;
				mem_addr = rd_addr;
			end
			ST_DATA_WAIT: begin
				res_d.status = STAT_OK;
				res_d.data_out = mem_rdata;
				res_d.data_valid = 1'b1;
				res_d.message_length = LEN_W'(rlen_q);
				if (off_next >= PW'(rlen_q)) begin
					tail_d = tail_q + PW'(HEADER_BYTES) + PW'(rlen_q);
					ractive_d = 1'b0;
					roff_d = '0;
					res_d.last_of_message = 1'b1;
				end else begin
					roff_d = off_next[AW-1:0];
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			tail_q <= '0;
			staged_q <= '0;
			fail_q <= STAT_OK;
			roff_q <= '0;
			rlen_q <= '0;
			ractive_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			tail_q <= tail_d;
			staged_q <= staged_d;
			fail_q <= fail_d;
			roff_q <= roff_d;
			rlen_q <= rlen_d;
			ractive_q <= ractive_d;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q <= cnt_d;
		hdr_q <= hdr_d;
		res_q <= res_d;
	end

	assign req_ready = (state_q == ST_IDLE);
	assign done_valid = (state_q == ST_DONE);

	always_comb begin
		done_rsp = res_q;
		done_rsp.used_bytes = USED_W'(used_w);
	end

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_w <= PW'(CAPACITY))
		else $error("ring holds more bytes than its capacity");

	a_staged_bound: assert property (@(posedge clk) disable iff (!arst_n)
		staged_q <= AW'(MAX_PAYLOAD))
		else $error("staged payload longer than the largest message");

	a_read_window: assert property (@(posedge clk) disable iff (!arst_n)
		ractive_q |-> (rlen_q != '0 && roff_q < rlen_q))
		else $error("open read outside its message");

	a_fail_code: assert property (@(posedge clk) disable iff (!arst_n)
		fail_q != STAT_EMPTY)
		else $error("write failure holds the empty-ring code");

	a_empty_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && req_valid && req.req_type == REQ_READ && !ractive_q
			&& used_w == '0)
		|=> (state_q == ST_DONE && res_q.status == STAT_EMPTY))
		else $error("read of an empty ring not flagged");
`endif

endmodule

// ----- rtl/length_prefixed_message_ring.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_message_ring
// Byte ring of length-prefixed messages over one single-port memory.
//
//   channel  handshake             payload  direction
//   req      req_valid/req_ready   req_t    in
//   rsp      rsp_valid/rsp_ready   rsp_t    out
//
// One transaction in, one transaction out. A payload write stores one byte;
// a committing write then writes four header bytes; a read of an open
// message reads one byte; the first read of a message first does four
// header byte fetches. The single memory port serializes these accesses.
// No clearing pass after reset. The result sits in an output register, so
// the next request is taken while rsp waits on rsp_ready.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring import lpmr_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);

	logic done_valid;
	logic done_ready;
	rsp_t done_rsp;
	logic mem_en;
	logic mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0] mem_wdata;
	logic [7:0] mem_rdata;
	logic rsp_valid_q;
	rsp_t rsp_q;

	lpmr_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.done_valid(done_valid),
		.done_ready(done_ready),
		.done_rsp(done_rsp),
		.mem_en(mem_en),
		.mem_we(mem_we),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	lpmr_ram #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.en(mem_en),
		.we(mem_we),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// load a new result when the slot is free or draining this cycle
	assign done_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done_valid && done_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_valid && done_ready) begin
			rsp_q <= done_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// ----- tb/length_prefixed_message_ring_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_checker
// Watches both channels of the message ring, keeps its own copy of the ring
// (byte store, head and tail, staging and read progress), predicts one
// response per accepted request and compares each accepted response, field
// by field, with the oldest prediction. Hands the failure count and the
// number of predictions still waiting to the testbench top.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_checker import lpmr_pkg::*; #(
	parameter int CAPACITY = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp,
	output int fail_count,
	output int outstanding
);

	localparam int MAX_PAYLOAD = CAPACITY - HEADER_BYTES;
	localparam int PTR_W = $clog2(CAPACITY) + 1;

	typedef logic [PTR_W-1:0] ring_ptr_t;

	logic [7:0] ring_mem [CAPACITY];
	ring_ptr_t head_ptr;
	ring_ptr_t tail_ptr;
	int staged_len;
	status_t wr_error;
	int rd_offset;
	int rd_length;
	bit rd_open;
	rsp_t expected_rsp_q [$];

	function automatic int ring_index(input int pos);
		return pos % CAPACITY;
	endfunction

	function automatic int ring_used();
		ring_ptr_t diff;
		diff = head_ptr - tail_ptr;
		return int'(diff);
	endfunction

	function automatic int ring_room();
		return (ring_used() >= CAPACITY) ? 0 : CAPACITY - ring_used();
	endfunction

	task automatic predict_response(input req_t r, output rsp_t e);
		int next_len;
		int room;
		int i;
		bit skip;
		logic [31:0] hdr;
		e = '0;
		if (r.req_type == REQ_WRITE) begin
			skip = r.empty_message & r.end_of_message;
			room = ring_room();
			// check length before free space; a failed message swallows the rest
			if (wr_error == STAT_OK) begin
				if (!skip) begin
					next_len = staged_len + 1;
					if (next_len > MAX_PAYLOAD)
						wr_error = STAT_TOO_LONG;
					else if (HEADER_BYTES + next_len > room)
						wr_error = STAT_NO_ROOM;
					else begin
						ring_mem[ring_index(int'(head_ptr) + HEADER_BYTES + staged_len)] =
							r.data_byte;
						staged_len = next_len;
					end
				end else if (HEADER_BYTES + staged_len > room) begin
					wr_error = STAT_NO_ROOM;
				end
			end
			if (!r.end_of_message) begin
				e.status = wr_error;
			end else if (wr_error != STAT_OK) begin
				e.status = wr_error;
				wr_error = STAT_OK;
				staged_len = 0;
			end else begin
				for (i = 0; i < HEADER_BYTES; i++)
					ring_mem[ring_index(int'(head_ptr) + i)] = 8'(staged_len >> (8 * i));
				head_ptr = ring_ptr_t'(int'(head_ptr) + HEADER_BYTES + staged_len);
				e.last_of_message = 1'b1;
				e.message_length = LEN_W'(staged_len);
				staged_len = 0;
			end
		end else if (!rd_open && ring_used() == 0) begin
			e.status = STAT_EMPTY;
		end else begin
			if (!rd_open) begin
				hdr = '0;
				for (i = 0; i < HEADER_BYTES; i++)
					hdr |= 32'(ring_mem[ring_index(int'(tail_ptr) + i)]) << (8 * i);
				rd_length = (hdr > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(hdr);
				rd_offset = 0;
				rd_open = 1'b1;
			end
			if (rd_length == 0) begin
				// zero-length message: free the header only
				tail_ptr = ring_ptr_t'(int'(tail_ptr) + HEADER_BYTES);
				rd_open = 1'b0;
				e.last_of_message = 1'b1;
			end else begin
				e.data_out = ring_mem[ring_index(int'(tail_ptr) + HEADER_BYTES + rd_offset)];
				e.data_valid = 1'b1;
				e.message_length = LEN_W'(rd_length);
				rd_offset++;
				if (rd_offset >= rd_length) begin
					tail_ptr = ring_ptr_t'(int'(tail_ptr) + HEADER_BYTES + rd_length);
					rd_open = 1'b0;
					rd_offset = 0;
					e.last_of_message = 1'b1;
				end
			end
		end
		e.used_bytes = USED_W'(ring_used());
	endtask

	task automatic compare_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_channels
		rsp_t predicted;
		rsp_t wanted;
		if (!arst_n) begin
			head_ptr = '0;
			tail_ptr = '0;
			staged_len = 0;
			wr_error = STAT_OK;
			rd_offset = 0;
			rd_length = 0;
			rd_open = 1'b0;
			expected_rsp_q.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (req_valid && req_ready) begin
				predict_response(req, predicted);
				expected_rsp_q.push_back(predicted);
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					$display("%0t: response with nothing expected, actual %p", $time, rsp);
					fail_count++;
				end else begin
					wanted = expected_rsp_q.pop_front();
					compare_field("status", wanted.status, rsp.status);
					compare_field("data_out", wanted.data_out, rsp.data_out);
					compare_field("data_valid", wanted.data_valid, rsp.data_valid);
					compare_field("last_of_message", wanted.last_of_message,
						rsp.last_of_message);
					compare_field("message_length", wanted.message_length,
						rsp.message_length);
					compare_field("used_bytes", wanted.used_bytes, rsp.used_bytes);
				end
			end
			outstanding <= expected_rsp_q.size();
		end
	end

endmodule

// ----- tb/length_prefixed_message_ring_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_tb
// Drives requests into the message ring: a short directed run over empty
// reads, zero-length and dropped-tail commits and the byte extremes, then
// random traffic under several idle and stall mixes with one long response
// hold-off. The checker beside the block predicts and compares; this top
// gives the verdict.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_tb;
	import lpmr_pkg::*;

	localparam int CAPACITY = 1024;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int fail_count;
	int outstanding;
	int sender_idle_pct = 0;
	int rsp_stall_pct = 0;
	bit hold_request = 1'b0;

	always #5 clk = ~clk;

	length_prefixed_message_ring #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	length_prefixed_message_ring_checker #(
		.CAPACITY(CAPACITY)
	) ring_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	task automatic send_item(input req_kind_t kind, input logic [7:0] value,
		input logic eom, input logic skip);
		req_valid <= 1'b1;
		req <= '{req_type: kind, data_byte: value, end_of_message: eom, empty_message: skip};
		do @(posedge clk); while (!req_ready);
		if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
	endtask

	task automatic read_items(input int count);
		int i;
		for (i = 0; i < count; i++)
			send_item(REQ_READ, 8'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic random_phase(input int n_items);
		int n;
		int remaining;
		bit drop_tail;
		remaining = -1;
		drop_tail = 1'b0;
		for (n = 0; n < n_items; n++) begin
			if ($urandom_range(99) < 6) begin
				send_item(req_kind_t'($urandom_range(1)), 8'($urandom), 1'($urandom),
					1'($urandom));
			end else if ($urandom_range(99) < 45) begin
				send_item(REQ_READ, 8'($urandom), 1'($urandom), 1'($urandom));
			end else begin
				if (remaining < 0) begin
					remaining = ($urandom_range(9) == 0) ? $urandom_range(300, 100) :
						$urandom_range(24);
					drop_tail = (remaining == 0) || ($urandom_range(3) == 0);
				end
				if (remaining == 0) begin
					// commit without this transaction's byte
					send_item(REQ_WRITE, 8'($urandom), 1'b1, 1'b1);
					remaining = -1;
				end else begin
					remaining--;
					if (remaining == 0 && !drop_tail) begin
						send_item(REQ_WRITE, 8'($urandom), 1'b1, 1'b0);
						remaining = -1;
					end else begin
						send_item(REQ_WRITE, 8'($urandom), 1'b0, 1'($urandom));
					end
				end
			end
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				rsp_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_request = 1'b0;
			end
			rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		read_items(1);
		send_item(REQ_WRITE, 8'h00, 1'b1, 1'b0);
		send_item(REQ_WRITE, 8'hFF, 1'b0, 1'b0);
		send_item(REQ_WRITE, 8'h81, 1'b1, 1'b0);
		send_item(REQ_WRITE, 8'hA5, 1'b1, 1'b1);
		send_item(REQ_WRITE, 8'h5A, 1'b0, 1'b0);
		send_item(REQ_WRITE, 8'h3C, 1'b1, 1'b1);
		send_item(REQ_WRITE, 8'hC3, 1'b0, 1'b1);
		send_item(REQ_READ, 8'hFF, 1'b1, 1'b1);
		send_item(REQ_WRITE, 8'h3C, 1'b1, 1'b0);
		read_items(7);

		hold_request = 1'b1;
		random_phase(100);
		sender_idle_pct = 51;
		rsp_stall_pct = 0;
		random_phase(100);
		sender_idle_pct = 0;
		rsp_stall_pct = 51;
		random_phase(100);
		sender_idle_pct = 15;
		rsp_stall_pct = 15;
		random_phase(100);

		req_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/lpmr_pkg.sv
rtl/lpmr_ram.sv
rtl/lpmr_ctrl.sv
rtl/length_prefixed_message_ring.sv
tb/length_prefixed_message_ring_checker.sv
tb/length_prefixed_message_ring_tb.sv
